>>> rtl/cnms_pkg.sv
package cnms_pkg;

	// register map indexes (byte address is 4 * index)
	localparam int unsigned REG_MODEL_WIDTH  = 0;
	localparam int unsigned REG_MODEL_HEIGHT = 1;
	localparam int unsigned REG_THRESHOLD    = 2;

	// field widths
	localparam int unsigned CoordW = 16;
	localparam int unsigned CatW   = 7;
	localparam int unsigned DimW   = 12;
	// shifted coordinate: 16 bit corner + 23 bit class shift + 16 bit size
	localparam int unsigned ShW    = 25;
	localparam int unsigned MulAW  = 16;
	localparam int unsigned MulBW  = 33;
	localparam int unsigned ProdW  = MulAW + MulBW;

	// defaults
	localparam int unsigned MAX_BOXES_DEF   = 64;
	localparam int unsigned MAX_CLASSES_DEF = 128;

	typedef enum logic [3:0] {
		S_LOAD,
		S_FIND_RD,
		S_FIND_CMP,
		S_BEST_RD,
		S_BEST_SH,
		S_BEST_AR,
		S_BEST_AA,
		S_CMP_RD,
		S_CMP_SH,
		S_CMP_GEO,
		S_CMP_INT,
		S_CMP_UNI,
		S_CMP_THR,
		S_CMP_DEC,
		S_EMIT
	} state_t;

endpackage

>>> rtl/class_aware_box_nms.sv
// Class-aware greedy non-maximum suppression.
// Boxes are written one request at a time: a request is taken at a rising edge with
// start high and busy low. Up to MAX_BOXES boxes are stored per frame; further ones
// are dropped and flag overflowed on every kept box of that frame. A request with
// final_box high ends the frame and the block goes busy while it suppresses.
// A box that is not final leaves busy low; a new request may follow at once.
// After the final box (n boxes stored, k kept), one shared 16x33 multiplier and one
// storage read port are stepped by the sequencer: each ranking scan reads all n entries,
// each kept box then takes the setup steps, one read per dead entry and the full
// compare per live entry, plus an emit step. Worst case is no suppression (k = n).
// Each kept box appears for one cycle with kept_valid high, the cycle after its emit
// step; end_of_list marks the last one. The receiver cannot stall, so results are
// never held back.
// APB registers: 0x0 model_width, 0x4 model_height, 0x8 overlap_threshold; write
// only while busy is low (the block does not check). Reset clears the box count,
// overflow flag and live marks and restores register defaults, but not box storage.
module class_aware_box_nms #(
	parameter int unsigned MAX_BOXES   = cnms_pkg::MAX_BOXES_DEF,
	parameter int unsigned MAX_CLASSES = cnms_pkg::MAX_CLASSES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// apb
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [3:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// box requests
	input  logic                         start,
	output logic                         busy,
	input  logic [cnms_pkg::CoordW-1:0] box_left,
	input  logic [cnms_pkg::CoordW-1:0] box_top,
	input  logic [cnms_pkg::CoordW-1:0] box_w,
	input  logic [cnms_pkg::CoordW-1:0] box_h,
	input  logic [cnms_pkg::CoordW-1:0] confidence,
	input  logic [cnms_pkg::CatW-1:0]   category,
	input  logic                         final_box,
	// results
	output logic                         kept_valid,
	output logic [cnms_pkg::CoordW-1:0] kept_left,
	output logic [cnms_pkg::CoordW-1:0] kept_top,
	output logic [cnms_pkg::CoordW-1:0] kept_w,
	output logic [cnms_pkg::CoordW-1:0] kept_h,
	output logic [cnms_pkg::CoordW-1:0] kept_confidence,
	output logic [cnms_pkg::CatW-1:0]   kept_category,
	output logic                         end_of_list,
	output logic                         overflowed
);
	import cnms_pkg::*;

	localparam int unsigned AW = $clog2(MAX_BOXES);
	localparam int unsigned NW = AW + 1;

	// configuration
	logic [DimW-1:0]   mw_q, mh_q;
	logic [CoordW-1:0] thr_q;
	logic              cfg_wr;
	logic [DimW-1:0]   mdim;

	// storage
	logic [4*CoordW-1:0] geo_mem [MAX_BOXES];
	logic [CoordW-1:0]   sc_mem  [MAX_BOXES];
	logic [CatW-1:0]     cat_mem [MAX_BOXES];
	logic [4*CoordW-1:0] geo_rd_q;
	logic [CoordW-1:0]   sc_rd_q;
	logic [CatW-1:0]     cat_rd_q;
	logic [AW-1:0]       rd_addr;

	// control
	state_t          state_q, state_d;
	logic [NW-1:0]   count_q, n_new;
	logic            ovf_q;
	logic [MAX_BOXES-1:0] alive_q;
	logic [AW-1:0]   idx_q, best_q;
	logic            found_q;
	logic [CoordW-1:0] bsc_q;
	logic            accept, store_en, idx_last, any_alive, better;

	// datapath
	logic [MulAW-1:0]  mul_a;
	logic [MulBW-1:0]  mul_b;
	logic [ProdW-1:0]  prod_q;
	logic [CatW-1:0]   cat_sat;
	logic [ShW-1:0]    shift_v;
	logic [ShW-1:0]    ax_q, ay_q, axr_q, ayb_q;
	logic [ShW-1:0]    bx, by, bxr, byb, xl, xr, yt, yb;
	logic [CoordW-1:0] iw_q, ih_q;
	logic [2*CoordW-1:0] aa_q, ba_q, inter_q;
	logic [MulBW-1:0]  uni_q;
	logic [4*CoordW-1:0] bgeo_q;
	logic [CoordW-1:0] bconf_q;
	logic [CatW-1:0]   bcat_q;
	logic              suppress;

	// apb
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign mdim   = (mw_q > mh_q) ? mw_q : mh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mw_q  <= DimW'(640);
			mh_q  <= DimW'(640);
			thr_q <= CoordW'(29491);
		end else if (cfg_wr) begin
			unique case (32'(paddr[3:2]))
				REG_MODEL_WIDTH:  mw_q  <= pwdata[DimW-1:0];
				REG_MODEL_HEIGHT: mh_q  <= pwdata[DimW-1:0];
				REG_THRESHOLD:    thr_q <= pwdata[CoordW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (32'(paddr[3:2]))
			REG_MODEL_WIDTH:  prdata = 32'(mw_q);
			REG_MODEL_HEIGHT: prdata = 32'(mh_q);
			REG_THRESHOLD:    prdata = 32'(thr_q);
			default:          prdata = '0;
		endcase
	end

	// request handling
	assign busy      = (state_q != S_LOAD);
	assign accept    = start & ~busy;
	assign store_en  = accept && (count_q < NW'(MAX_BOXES));
	assign n_new     = store_en ? count_q + NW'(1) : count_q;
	assign idx_last  = (idx_q == AW'(count_q - NW'(1)));
	assign any_alive = |alive_q;
	assign better    = alive_q[idx_q] && (!found_q || (sc_rd_q > bsc_q));

	// storage write and registered read
	always_comb begin
		unique case (state_q)
			S_FIND_RD, S_FIND_CMP:             rd_addr = idx_q;
			S_BEST_RD, S_BEST_SH:              rd_addr = best_q;
			default:                           rd_addr = idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (store_en) begin
			geo_mem[count_q[AW-1:0]] <= {box_h, box_w, box_top, box_left};
			sc_mem[count_q[AW-1:0]]  <= confidence;
			cat_mem[count_q[AW-1:0]] <= category;
		end
		geo_rd_q <= geo_mem[rd_addr];
		sc_rd_q  <= sc_mem[rd_addr];
		cat_rd_q <= cat_mem[rd_addr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD:     if (accept && final_box) state_d = S_FIND_RD;
			S_FIND_RD:  state_d = S_FIND_CMP;
			S_FIND_CMP: state_d = idx_last ? S_BEST_RD : S_FIND_RD;
			S_BEST_RD:  state_d = S_BEST_SH;
			S_BEST_SH:  state_d = S_BEST_AR;
			S_BEST_AR:  state_d = S_BEST_AA;
			S_BEST_AA:  state_d = S_CMP_RD;
			S_CMP_RD: begin
				if (alive_q[idx_q]) state_d = S_CMP_SH;
				else if (idx_last)  state_d = S_EMIT;
			end
			S_CMP_SH:   state_d = S_CMP_GEO;
			S_CMP_GEO:  state_d = S_CMP_INT;
			S_CMP_INT:  state_d = S_CMP_UNI;
			S_CMP_UNI:  state_d = S_CMP_THR;
			S_CMP_THR:  state_d = S_CMP_DEC;
			S_CMP_DEC:  state_d = idx_last ? S_EMIT : S_CMP_RD;
			S_EMIT:     state_d = any_alive ? S_FIND_RD : S_LOAD;
			default:    state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_LOAD;
		else         state_q <= state_d;
	end

	// shared multiplier operand select
	assign cat_sat = ({1'b0, cat_rd_q} >= (CatW+1)'(MAX_CLASSES)) ?
		CatW'(MAX_CLASSES - 1) : cat_rd_q;

	always_comb begin
		unique case (state_q)
			S_BEST_SH, S_CMP_SH: begin
				mul_a = MulAW'(mdim);
				mul_b = MulBW'(cat_sat);
			end
			S_BEST_AR: begin
				mul_a = bgeo_q[3*CoordW +: CoordW];
				mul_b = MulBW'(bgeo_q[2*CoordW +: CoordW]);
			end
			S_CMP_GEO: begin
				mul_a = geo_rd_q[3*CoordW +: CoordW];
				mul_b = MulBW'(geo_rd_q[2*CoordW +: CoordW]);
			end
			S_CMP_INT: begin
				mul_a = iw_q;
				mul_b = MulBW'(ih_q);
			end
			default: begin
				mul_a = thr_q;
				mul_b = uni_q;
			end
		endcase
	end

	// compared box geometry, shifted by class
	assign shift_v = ShW'({prod_q[18:0], 4'b0});
	assign bx  = ShW'(geo_rd_q[0 +: CoordW]) + shift_v;
	assign by  = ShW'(geo_rd_q[CoordW +: CoordW]) + shift_v;
	assign bxr = bx + ShW'(geo_rd_q[2*CoordW +: CoordW]);
	assign byb = by + ShW'(geo_rd_q[3*CoordW +: CoordW]);
	assign xl  = (ax_q > bx) ? ax_q : bx;
	assign yt  = (ay_q > by) ? ay_q : by;
	assign xr  = (axr_q < bxr) ? axr_q : bxr;
	assign yb  = (ayb_q < byb) ? ayb_q : byb;

	assign suppress = (uni_q != '0) && ({inter_q, 16'b0} > prod_q[ProdW-2:0])
		&& !prod_q[ProdW-1];

	// sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			alive_q <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
			best_q  <= '0;
			kept_valid <= 1'b0;
		end else begin
			kept_valid <= (state_q == S_EMIT);
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						count_q <= n_new;
						if (!store_en) ovf_q <= 1'b1;
						if (final_box) begin
							for (int k = 0; k < MAX_BOXES; k++)
								alive_q[k] <= (NW'(k) < n_new);
							idx_q   <= '0;
							found_q <= 1'b0;
						end
					end
				end
				S_FIND_CMP: begin
					if (better) begin
						found_q <= 1'b1;
						best_q  <= idx_q;
					end
					idx_q <= idx_last ? '0 : idx_q + AW'(1);
				end
				S_BEST_RD: alive_q[best_q] <= 1'b0;
				S_CMP_RD: begin
					if (!alive_q[idx_q]) idx_q <= idx_last ? '0 : idx_q + AW'(1);
				end
				S_CMP_DEC: begin
					if (suppress) alive_q[idx_q] <= 1'b0;
					idx_q <= idx_last ? '0 : idx_q + AW'(1);
				end
				S_EMIT: begin
					idx_q      <= '0;
					found_q    <= 1'b0;
					if (!any_alive) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		prod_q <= ProdW'(mul_a * mul_b);
		if (state_q == S_FIND_CMP && better) bsc_q <= sc_rd_q;
		if (state_q == S_BEST_SH) begin
			bgeo_q  <= geo_rd_q;
			bconf_q <= sc_rd_q;
			bcat_q  <= cat_rd_q;
		end
		if (state_q == S_BEST_AR) begin
			ax_q  <= ShW'(bgeo_q[0 +: CoordW]) + shift_v;
			ay_q  <= ShW'(bgeo_q[CoordW +: CoordW]) + shift_v;
			axr_q <= ShW'(bgeo_q[0 +: CoordW]) + shift_v + ShW'(bgeo_q[2*CoordW +: CoordW]);
			ayb_q <= ShW'(bgeo_q[CoordW +: CoordW]) + shift_v
				+ ShW'(bgeo_q[3*CoordW +: CoordW]);
		end
		if (state_q == S_BEST_AA) aa_q <= prod_q[2*CoordW-1:0];
		if (state_q == S_CMP_GEO) begin
			iw_q <= (xr > xl) ? CoordW'(xr - xl) : '0;
			ih_q <= (yb > yt) ? CoordW'(yb - yt) : '0;
		end
		if (state_q == S_CMP_INT) ba_q <= prod_q[2*CoordW-1:0];
		if (state_q == S_CMP_UNI) begin
			inter_q <= prod_q[2*CoordW-1:0];
			uni_q   <= MulBW'(aa_q) + MulBW'(ba_q) - MulBW'(prod_q[2*CoordW-1:0]);
		end
		if (state_q == S_EMIT) begin
			kept_left       <= bgeo_q[0 +: CoordW];
			kept_top        <= bgeo_q[CoordW +: CoordW];
			kept_w          <= bgeo_q[2*CoordW +: CoordW];
			kept_h          <= bgeo_q[3*CoordW +: CoordW];
			kept_confidence <= bconf_q;
			kept_category   <= bcat_q;
			end_of_list     <= ~any_alive;
			overflowed      <= ovf_q;
		end
	end

	// checks
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> (alive_q == '0))
		else $error("live marks left over while idle");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(MAX_BOXES))
		else $error("box count beyond capacity");
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		kept_valid |-> $past(state_q == S_EMIT))
		else $error("result strobe without emit");
	a_best_dead: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BEST_SH) |-> !alive_q[best_q])
		else $error("kept box still marked live");

endmodule

>>> dv/tb_class_aware_box_nms.sv
`timescale 1ns / 100ps

module tb_class_aware_box_nms;
	import cnms_pkg::*;

	localparam int unsigned NBOX = 64;
	localparam int unsigned NCLS = 128;

	typedef struct {
		logic [15:0] left;
		logic [15:0] top;
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] conf;
		logic [6:0]  cat;
		logic        last;
		logic        ovf;
	} box_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic start;
	logic busy;
	logic [15:0] box_left, box_top, box_w, box_h, confidence;
	logic [6:0] category;
	logic final_box;
	logic kept_valid;
	logic [15:0] kept_left, kept_top, kept_w, kept_h, kept_confidence;
	logic [6:0] kept_category;
	logic end_of_list, overflowed;

	// predictor state
	logic [11:0] cur_width, cur_height;
	logic [15:0] cur_thresh;
	box_t frame_boxes[NBOX];
	int unsigned frame_count;
	bit frame_overflow;
	box_t kept_queue[$];
	int unsigned fail_count;

	class_aware_box_nms DUT (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#20000000;
		$display("FAILED: results differ");
		$finish;
	end

	// shifted-box overlap test, true when b is suppressed by a
	function automatic bit overlaps(box_t a, box_t b);
		longint m, sa, sb, ax, ay, bx, by, xl, yt, xr, yb, iw, ih, inter, uni;
		m = (cur_width > cur_height) ? cur_width : cur_height;
		sa = m * 16 * ((a.cat >= NCLS) ? NCLS - 1 : a.cat);
		sb = m * 16 * ((b.cat >= NCLS) ? NCLS - 1 : b.cat);
		ax = a.left + sa;
		ay = a.top + sa;
		bx = b.left + sb;
		by = b.top + sb;
		xl = (ax > bx) ? ax : bx;
		yt = (ay > by) ? ay : by;
		xr = ((ax + a.w) < (bx + b.w)) ? ax + a.w : bx + b.w;
		yb = ((ay + a.h) < (by + b.h)) ? ay + a.h : by + b.h;
		iw = (xr > xl) ? xr - xl : 0;
		ih = (yb > yt) ? yb - yt : 0;
		inter = iw * ih;
		uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
		if (uni <= 0)
			return 1'b0;
		return inter * 65536 > longint'(cur_thresh) * uni;
	endfunction

	// store a box and, on the last one, rank and suppress the frame
	task automatic predict_box(box_t b);
		int unsigned rank[NBOX];
		bit live[NBOX];
		int unsigned n, j;
		if (frame_count < NBOX) begin
			frame_boxes[frame_count] = b;
			frame_count++;
		end else begin
			frame_overflow = 1'b1;
		end
		if (!b.last)
			return;
		n = frame_count;
		for (int unsigned i = 0; i < n; i++) begin
			j = i;
			while (j > 0 && frame_boxes[rank[j-1]].conf < frame_boxes[i].conf) begin
				rank[j] = rank[j-1];
				j--;
			end
			rank[j] = i;
			live[i] = 1'b1;
		end
		for (int unsigned i = 0; i < n; i++) begin
			box_t k;
			if (!live[i])
				continue;
			for (int unsigned q = i + 1; q < n; q++)
				if (live[q] && overlaps(frame_boxes[rank[i]], frame_boxes[rank[q]]))
					live[q] = 1'b0;
			k = frame_boxes[rank[i]];
			k.last = 1'b0;
			k.ovf = frame_overflow;
			kept_queue = {kept_queue, k};
		end
		kept_queue[kept_queue.size()-1].last = 1'b1;
		frame_count = 0;
		frame_overflow = 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && kept_valid) begin
			if (kept_queue.size() == 0) begin
				$error("unexpected kept box");
				fail_count++;
			end else begin
				box_t e;
				e = kept_queue.pop_front();
				if (kept_left !== e.left) begin
					$error("kept_left exp %0h got %0h", e.left, kept_left); fail_count++;
				end
				if (kept_top !== e.top) begin
					$error("kept_top exp %0h got %0h", e.top, kept_top); fail_count++;
				end
				if (kept_w !== e.w) begin
					$error("kept_w exp %0h got %0h", e.w, kept_w); fail_count++;
				end
				if (kept_h !== e.h) begin
					$error("kept_h exp %0h got %0h", e.h, kept_h); fail_count++;
				end
				if (kept_confidence !== e.conf) begin
					$error("kept_confidence exp %0h got %0h", e.conf, kept_confidence);
					fail_count++;
				end
				if (kept_category !== e.cat) begin
					$error("kept_category exp %0h got %0h", e.cat, kept_category);
					fail_count++;
				end
				if (end_of_list !== e.last) begin
					$error("end_of_list exp %0b got %0b", e.last, end_of_list); fail_count++;
				end
				if (overflowed !== e.ovf) begin
					$error("overflowed exp %0b got %0b", e.ovf, overflowed); fail_count++;
				end
			end
		end
	end

	// random gap before a request, mostly short; start drops during the gap
	task automatic idle_gap();
		int unsigned g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			g = 0;
		if (g != 0) begin
			start <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	// send one box request, start stays high until the next negedge that changes it
	task automatic send_box(box_t b, bit gaps);
		@(negedge clk);
		if (gaps)
			idle_gap();
		start      <= 1'b1;
		box_left   <= b.left;
		box_top    <= b.top;
		box_w      <= b.w;
		box_h      <= b.h;
		confidence <= b.conf;
		category   <= b.cat;
		final_box  <= b.last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_box(b);
	endtask

	// wait until all kept boxes of the last frame came out
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (kept_queue.size() != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// apb register write, block idle
	task automatic write_reg(int unsigned idx, logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= 4'(idx * 4);
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_MODEL_WIDTH:  cur_width = val[11:0];
			REG_MODEL_HEIGHT: cur_height = val[11:0];
			REG_THRESHOLD:    cur_thresh = val[15:0];
			default: ;
		endcase
	endtask

	function automatic box_t rand_box(bit clustered, bit last);
		box_t b;
		b.left = clustered ? 16'($urandom_range(0, 400)) : 16'($urandom);
		b.top  = clustered ? 16'($urandom_range(0, 400)) : 16'($urandom);
		b.w    = clustered ? 16'($urandom_range(0, 600)) : 16'($urandom);
		b.h    = clustered ? 16'($urandom_range(0, 600)) : 16'($urandom);
		b.conf = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
		b.cat  = clustered ? 7'($urandom_range(0, 2)) : 7'($urandom);
		b.last = last;
		b.ovf  = 1'b0;
		return b;
	endfunction

	function automatic box_t mk(int l, int t, int w, int h, int c, int k, bit last);
		box_t b;
		b.left = 16'(l); b.top = 16'(t); b.w = 16'(w); b.h = 16'(h);
		b.conf = 16'(c); b.cat = 7'(k); b.last = last; b.ovf = 1'b0;
		return b;
	endfunction

	// directed frames: overlap, ties, class split, extremes, zero area
	task automatic test_directed();
		send_box(mk(0, 0, 160, 160, 1000, 0, 0), 0);
		send_box(mk(8, 8, 160, 160, 2000, 0, 0), 0);
		send_box(mk(0, 0, 160, 160, 2000, 1, 0), 0);
		send_box(mk(800, 800, 16, 16, 2000, 0, 1), 0);
		drain();
		send_box(mk(65535, 65535, 65535, 65535, 65535, 127, 0), 0);
		send_box(mk(0, 0, 0, 0, 0, 0, 0), 0);
		send_box(mk(0, 0, 0, 0, 0, 0, 0), 0);
		send_box(mk(65535, 65535, 65535, 65535, 65535, 127, 1), 0);
		drain();
		send_box(mk(5, 5, 0, 0, 7, 3, 1), 0);
		drain();
	endtask

	// fill beyond capacity, with a dropped final box
	task automatic test_overflow();
		for (int i = 0; i < NBOX + 3; i++)
			send_box(rand_box(1, i == NBOX + 2), 0);
		drain();
	endtask

	// register settings including extremes
	task automatic test_config(logic [31:0] w, logic [31:0] h, logic [31:0] t, int nbox);
		write_reg(REG_MODEL_WIDTH, w);
		write_reg(REG_MODEL_HEIGHT, h);
		write_reg(REG_THRESHOLD, t);
		for (int i = 0; i < nbox; i++)
			send_box(rand_box(1, i == nbox - 1), 1);
		drain();
	endtask

	// random frames, mostly small and clustered
	task automatic test_random(int unsigned total);
		int unsigned sent, nf;
		sent = 0;
		while (sent < total) begin
			nf = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
			for (int unsigned i = 0; i < nf; i++)
				send_box(rand_box($urandom_range(0, 4) != 0, i == nf - 1), 1);
			sent += nf;
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		start = 0; box_left = 0; box_top = 0; box_w = 0; box_h = 0;
		confidence = 0; category = 0; final_box = 0;
		cur_width = 12'd640; cur_height = 12'd640; cur_thresh = 16'd29491;
		frame_count = 0; frame_overflow = 0; fail_count = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_overflow();
		test_config(32'h0000_0fff, 32'h0000_0001, 32'h0000_0000, 10);
		test_config(32'h0000_0000, 32'h0000_0000, 32'h0000_ffff, 10);
		test_config(32'h0000_0001, 32'h0000_0fff, 32'h0000_8000, 10);
		test_config(32'hffff_f280, 32'hffff_f1e0, 32'h0001_4ccd, 10);
		test_random(90);
		test_config(32'd640, 32'd640, 32'd29491, 4);
		test_random(90);
		repeat (50) @(negedge clk);
		if (fail_count == 0 && kept_queue.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> filelist.f
rtl/cnms_pkg.sv
rtl/class_aware_box_nms.sv
dv/tb_class_aware_box_nms.sv
